>>> rtl/core/lswc_pkg.sv
// Shared types and constants of the load-state window classifier.
`default_nettype none
package lswc_pkg;

    localparam int CNT_W = 4;
    localparam int LVL_W = 10;
    localparam int TMO_W = 8;

    localparam logic [LVL_W-1:0] HIGH_LEVEL_RST     = 10'd500;
    localparam logic [LVL_W-1:0] JUMP_THRESHOLD_RST = 10'd200;
    localparam logic [TMO_W-1:0] OFF_LIMIT_RST      = 8'd20;
    localparam logic [TMO_W-1:0] ON_LIMIT_RST       = 8'd2;

    typedef enum logic [1:0] {
        CFG_HIGH_LEVEL     = 2'd0,
        CFG_JUMP_THRESHOLD = 2'd1,
        CFG_OFF_LIMIT      = 2'd2,
        CFG_ON_LIMIT       = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OFF    = 2'd0,
        ST_ON     = 2'd1,
        ST_TOGGLE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_OK   = 2'd1,
        ACT_FAIL = 2'd2
    } t_action;

    typedef struct packed {
        logic [LVL_W-1:0] high_level;
        logic [LVL_W-1:0] jump_threshold;
        logic [TMO_W-1:0] off_limit;
        logic [TMO_W-1:0] on_limit;
    } t_cfg;

    typedef struct packed {
        logic p_on;
        logic p_off;
        logic p_frc;
    } t_pend;

    typedef struct packed {
        logic [CNT_W-1:0] idx;
        logic [LVL_W-1:0] prev;
        logic [CNT_W-1:0] cc;
        logic [CNT_W-1:0] hc;
        t_status          status;
        t_action          action;
        t_pend            pend;
        logic [TMO_W-1:0] tmo;
    } t_state;

    typedef struct packed {
        logic             req_on;
        logic             req_off;
        logic             req_force;
        logic [LVL_W-1:0] level;
    } t_item;

    typedef struct packed {
        logic    action_changed;
        t_action action_code;
        t_status line_status;
    } t_result;

    function automatic logic [TMO_W-1:0] sat_inc(input logic [TMO_W-1:0] v);
        sat_inc = (v == {TMO_W{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/load_state_window_classifier.sv
// Top level of the load-state window classifier: input stage, state and result register.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tdata[15:0] level, req_force, req_off, req_on
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata[7:0]  line_status, action_code, changed
//  cfg       in   i_cfg_we (no wait)             i_cfg_idx, i_cfg_data
//
// One sample per cycle sustained, unless a window end waits on the result register:
// a transfer lands in the input register, and the step logic updates the window
// state from it. Only the last sample of a window produces a result, loaded at the
// edge that processes its input register, so it passes the input register, then the result register.
// Reset (i_rst_n low, synchronous) clears state, valids and loads register defaults.
// A stalled result stalls the step only if the result register is still full
// when the next window end comes up; other samples keep flowing.
`default_nettype none
module load_state_window_classifier
    import lswc_pkg::*;
#(
    parameter int WINDOW = 15
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // stream in
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [9:0] level, [10] req_force, [11] req_off,
                                             // [12] req_on, [15:13] zero
    // stream out
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [1:0] line_status, [3:2] action_code,
                                             // [4] action_changed, [7:5] zero
    // configuration writes
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [9:0]  i_cfg_data
);

    t_cfg    r_cfg;
    t_state  r_st;
    t_state  n_st;
    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result n_out;
    logic    n_last;
    logic    proc_go;

    lswc_step #(
        .WINDOW (WINDOW)
    ) u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_st),
        .i_item   (r_in),
        .o_state  (n_st),
        .o_last   (n_last),
        .o_result (n_out)
    );

    // a window-end sample may only go when the result register is free
    assign proc_go       = r_in_valid && (!n_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || proc_go;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out};

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.high_level     <= HIGH_LEVEL_RST;
            r_cfg.jump_threshold <= JUMP_THRESHOLD_RST;
            r_cfg.off_limit      <= OFF_LIMIT_RST;
            r_cfg.on_limit       <= ON_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_HIGH_LEVEL:     r_cfg.high_level     <= i_cfg_data;
                CFG_JUMP_THRESHOLD: r_cfg.jump_threshold <= i_cfg_data;
                CFG_OFF_LIMIT:      r_cfg.off_limit      <= i_cfg_data[TMO_W-1:0];
                CFG_ON_LIMIT:       r_cfg.on_limit       <= i_cfg_data[TMO_W-1:0];
                default:            ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in <= s_axis_tdata[12:0];
        end
    end

    // window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (proc_go) begin
            r_st <= n_st;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_go && n_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_go && n_last) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    localparam logic [CNT_W-1:0] WIN_CNT_A = CNT_W'(WINDOW);

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.idx < WIN_CNT_A)
        else $error("sample index beyond window");

    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.cc <= r_st.idx) && (r_st.hc <= r_st.idx))
        else $error("window counters exceed samples seen");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_go && n_last) |=> r_out_valid)
        else $error("window end did not load a result");

    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(proc_go && n_last))
        else $error("result appeared without a window end");
`endif

endmodule
`default_nettype wire

>>> rtl/core/lswc_step.sv
// Per-sample update: counting, window-end classification and request resolution.
`default_nettype none
module lswc_step
    import lswc_pkg::*;
#(
    parameter int WINDOW = 15
) (
    input  t_cfg    i_cfg,
    input  t_state  i_state,
    input  t_item   i_item,
    output t_state  o_state,
    output logic    o_last,
    output t_result o_result
);

    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(WINDOW - 1);
    localparam logic [CNT_W-1:0] WIN_CNT  = CNT_W'(WINDOW);

    always_comb begin
        t_state           s;
        logic [LVL_W-1:0] prev;
        logic             hi;
        logic             jump;
        t_action          old_act;

        s = i_state;
        // requests latch ahead of the sample
        if (i_item.req_force) begin
            s.pend.p_frc = 1'b1;
        end
        if (i_item.req_off) begin
            s.pend.p_off = 1'b1;
            s.tmo        = '0;
        end
        if (i_item.req_on) begin
            s.pend.p_on = 1'b1;
            s.tmo       = '0;
        end

        prev = (i_state.idx == '0) ? i_item.level : i_state.prev;
        hi   = i_item.level > i_cfg.high_level;
        if (hi) begin
            jump = (i_item.level > prev) && ((i_item.level - prev) > i_cfg.jump_threshold);
        end else begin
            jump = (prev > i_item.level) && ((prev - i_item.level) > i_cfg.jump_threshold);
        end

        s.hc   = s.hc + CNT_W'(hi);
        s.cc   = s.cc + CNT_W'(jump);
        s.prev = i_item.level;
        s.idx  = s.idx + 1'b1;

        o_last  = (i_state.idx == LAST_IDX);
        old_act = i_state.action;

        if (o_last) begin
            priority if (s.cc == '0) begin
                if (s.hc >= WIN_CNT) begin
                    s.status = ST_ON;
                end else if (s.hc == '0) begin
                    s.status = ST_OFF;
                end
            end else if (s.cc == CNT_W'(1)) begin
                s.status = hi ? ST_ON : ST_OFF;
            end else begin
                s.status = ST_TOGGLE;
            end

            if (s.pend.p_frc) begin
                s.pend.p_frc = 1'b0;
                s.action     = (s.status == ST_OFF) ? ACT_OK : ACT_FAIL;
            end
            if (s.pend.p_off) begin
                s.tmo = sat_inc(s.tmo);
                if (s.status == ST_OFF || s.status == ST_TOGGLE) begin
                    s.pend.p_off = 1'b0;
                    s.action     = ACT_OK;
                end else if (s.tmo > i_cfg.off_limit) begin
                    s.pend.p_off = 1'b0;
                    s.action     = ACT_FAIL;
                end
            end
            if (s.pend.p_on) begin
                s.tmo = sat_inc(s.tmo);
                if (s.status == ST_ON) begin
                    s.pend.p_on = 1'b0;
                    s.action    = ACT_OK;
                end else if (s.tmo > i_cfg.on_limit) begin
                    s.pend.p_on = 1'b0;
                    s.action    = ACT_FAIL;
                end
            end

            s.idx = '0;
            s.cc  = '0;
            s.hc  = '0;
        end

        o_state                 = s;
        o_result.line_status    = s.status;
        o_result.action_code    = s.action;
        o_result.action_changed = (old_act != s.action);
    end

endmodule
`default_nettype wire

>>> dv/load_state_window_classifier_tb.sv
// Self-checking testbench: directed window, randomised phases and a timeout run.
`timescale 1ns / 1ps
module load_state_window_classifier_tb;
    import lswc_pkg::*;

    localparam int WINDOW    = 15;
    localparam int SETTLE    = 6;          // input register, step, result register, margin
    localparam int CYCLE_CAP = 1_000_000;

    // Window shapes for the random part; chosen afresh at each window start.
    typedef enum int {
        SHAPE_HIGH, SHAPE_LOW, SHAPE_STEP, SHAPE_TOGGLE, SHAPE_EDGE, SHAPE_NOISE
    } t_shape;

    typedef struct {
        logic [9:0] hl;
        logic [9:0] jt;
        logic [7:0] offl;
        logic [7:0] onl;
        int         wins;      // whole windows in the phase
        int         div;       // request odds 1 in div per sample, 0 for none
        bit         quiet;     // no idling on either side
        bit         draw;      // registers drawn at random
        bit         hold;      // every window held above high_level
        bit         arm;       // raise one off request at the first window start
    } t_phase;

    typedef struct packed {
        logic [9:0] lvl;
        logic       frc;
        logic       off;
        logic       on;
        logic       typed;
        t_result    want;
    } t_row;

    localparam t_result NO_RES = '0;
    // Directed window: many jumps -> toggling; force fails, then off succeeds.
    localparam t_result TOGGLE_OK_NEW = '{action_changed: 1'b1, action_code: ACT_OK,
                                          line_status: ST_TOGGLE};

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;   // [9:0] level, [10] req_force, [11] req_off, [12] req_on
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // [1:0] line_status, [3:2] action_code, [4] changed
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_idx     = '0;
    logic [9:0]  i_cfg_data    = '0;

    load_state_window_classifier #(
        .WINDOW(WINDOW)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // ---------------------------------------------------------------------
    // Predictor state: registers as last written, window counters and the
    // request bookkeeping, all at the block's own widths.
    // ---------------------------------------------------------------------
    logic [9:0] cfg_high    = HIGH_LEVEL_RST;
    logic [9:0] cfg_jump    = JUMP_THRESHOLD_RST;
    logic [7:0] cfg_off_lim = OFF_LIMIT_RST;
    logic [7:0] cfg_on_lim  = ON_LIMIT_RST;

    logic [3:0] win_pos     = '0;
    logic [3:0] win_jumps   = '0;
    logic [3:0] win_highs   = '0;
    logic [9:0] last_lvl    = '0;
    t_status    line_st     = ST_OFF;
    t_action    act_st      = ACT_NONE;
    t_pend      pend        = '0;
    logic [7:0] tmo_cnt     = '0;

    t_result    results_due [$];

    int         n_errors    = 0;
    int         n_samples   = 0;
    int         n_results   = 0;
    int         n_cfg       = 0;
    int         st_seen [4] = '{0, 0, 0, 0};
    int         act_seen [4] = '{0, 0, 0, 0};
    int         cycle_cnt   = 0;
    int         rx_hold     = 0;
    bit         quiet       = 1'b0;

    t_shape     shape       = SHAPE_NOISE;
    int         step_at     = 1;
    bit         rising      = 1'b0;

    t_result    got_res;
    t_result    want_res;

    // Apply one sample to the predictor; returns 1 with the window result at window end.
    function automatic bit classify_sample(input t_item it, output t_result res);
        t_action act_before;
        res = NO_RES;
        // requests latch before the sample itself is handled
        if (it.req_force)
            pend.p_frc = 1'b1;
        if (it.req_off) begin
            pend.p_off = 1'b1;
            tmo_cnt    = '0;
        end
        if (it.req_on) begin
            pend.p_on = 1'b1;
            tmo_cnt   = '0;
        end
        // first sample of a window seeds the comparison, never a jump
        if (win_pos == 0)
            last_lvl = it.level;
        if (it.level > cfg_high) begin
            win_highs++;
            if (it.level > last_lvl && it.level - last_lvl > cfg_jump)
                win_jumps++;
        end else if (last_lvl > it.level && last_lvl - it.level > cfg_jump) begin
            win_jumps++;
        end
        last_lvl = it.level;
        win_pos++;
        if (win_pos < WINDOW)
            return 1'b0;

        if (win_jumps == 0) begin
            if (win_highs >= WINDOW)
                line_st = ST_ON;
            else if (win_highs == 0)
                line_st = ST_OFF;
        end else if (win_jumps == 1) begin
            line_st = (it.level > cfg_high) ? ST_ON : ST_OFF;
        end else begin
            line_st = ST_TOGGLE;
        end

        act_before = act_st;
        if (pend.p_frc) begin
            pend.p_frc = 1'b0;
            act_st     = (line_st == ST_OFF) ? ACT_OK : ACT_FAIL;
        end
        if (pend.p_off) begin
            if (tmo_cnt != 8'hFF)
                tmo_cnt++;
            if (line_st == ST_OFF || line_st == ST_TOGGLE) begin
                pend.p_off = 1'b0;
                act_st     = ACT_OK;
            end else if (tmo_cnt > cfg_off_lim) begin
                pend.p_off = 1'b0;
                act_st     = ACT_FAIL;
            end
        end
        if (pend.p_on) begin
            if (tmo_cnt != 8'hFF)
                tmo_cnt++;
            if (line_st == ST_ON) begin
                pend.p_on = 1'b0;
                act_st    = ACT_OK;
            end else if (tmo_cnt > cfg_on_lim) begin
                pend.p_on = 1'b0;
                act_st    = ACT_FAIL;
            end
        end

        win_pos   = '0;
        win_jumps = '0;
        win_highs = '0;
        res.line_status    = line_st;
        res.action_code    = act_st;
        res.action_changed = (act_st != act_before);
        return 1'b1;
    endfunction

    // Idle length: mostly none, some short, a few long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // Sample level for position pos of the current window shape.
    function automatic logic [9:0] pick_level(input int pos);
        int         hl;
        logic [9:0] hi_v;
        logic [9:0] lo_v;
        hl   = cfg_high;
        hi_v = (hl >= 1023) ? 10'd1023 : 10'($urandom_range(hl + 1, 1023));
        lo_v = 10'($urandom_range(0, hl));
        case (shape)
            SHAPE_HIGH:   return hi_v;
            SHAPE_LOW:    return lo_v;
            SHAPE_STEP:   return ((pos >= step_at) == rising) ? hi_v : lo_v;
            SHAPE_TOGGLE: return (pos[0] ^ ($urandom_range(0, 4) == 0)) ? 10'd1023 : 10'd0;
            SHAPE_EDGE:   return 10'($urandom_range((hl < 3) ? 0 : hl - 3,
                                                    (hl > 1020) ? 1023 : hl + 3));
            default:      return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    // One input transfer; the predictor runs on the accepting edge.
    task automatic send_sample(input t_item it, output bit ended, output t_result res);
        int gap;
        gap = gap_len();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, it};
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        n_samples++;
        ended = classify_sample(it, res);
    endtask

    // Hold the sender until every window result is back and the pipe is empty.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Write all four registers on consecutive edges; enable stays high throughout.
    task automatic load_regs(input logic [9:0] hl, input logic [9:0] jt,
                             input logic [7:0] offl, input logic [7:0] onl);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_HIGH_LEVEL;
        i_cfg_data <= hl;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_JUMP_THRESHOLD;
        i_cfg_data <= jt;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_OFF_LIMIT;
        i_cfg_data <= {2'b00, offl};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_ON_LIMIT;
        i_cfg_data <= {2'b00, onl};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_high    = hl;
        cfg_jump    = jt;
        cfg_off_lim = offl;
        cfg_on_lim  = onl;
        n_cfg++;
    endtask

    // Result side: random back-pressure, quiet phases excepted.
    always @(posedge i_clk) begin
        if (rx_hold != 0) begin
            m_axis_tready <= 1'b0;
            rx_hold       <= rx_hold - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 5) == 0)
                rx_hold <= gap_len();
        end
    end

    // Compare each result transfer with the oldest outstanding window result.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_res = m_axis_tdata[4:0];
            n_results++;
            st_seen[got_res.line_status]++;
            act_seen[got_res.action_code]++;
            if (results_due.size() == 0) begin
                $error("unexpected result transfer, tdata %h", m_axis_tdata);
                n_errors++;
            end else begin
                want_res = results_due.pop_front();
                if (got_res.line_status !== want_res.line_status) begin
                    $error("line_status: expected %0d, got %0d",
                           want_res.line_status, got_res.line_status);
                    n_errors++;
                end
                if (got_res.action_code !== want_res.action_code) begin
                    $error("action_code: expected %0d, got %0d",
                           want_res.action_code, got_res.action_code);
                    n_errors++;
                end
                if (got_res.action_changed !== want_res.action_changed) begin
                    $error("action_changed: expected %0d, got %0d",
                           want_res.action_changed, got_res.action_changed);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_CAP) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        t_row    dir_tab [15];
        t_phase  plan [11];
        t_item   it;
        t_result res;
        bit      ended;
        int      n_items;

        // Reset defaults: level extremes, every request bit, force early in the
        // window, on and off both raised late so both bump the timeout, and an
        // off request on the closing sample resolved at this very window end.
        dir_tab = '{
            '{10'd0,    1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
            '{10'd1023, 1'b1, 1'b0, 1'b0, 1'b0, NO_RES},
            '{10'd1023, 1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
            '{10'd0,    1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
            '{10'd501,  1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
            '{10'd500,  1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
            '{10'd700,  1'b0, 1'b0, 1'b0, 1'b0, NO_RES},  // rise of exactly the threshold
            '{10'd500,  1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
            '{10'd1023, 1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
            '{10'd1023, 1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
            '{10'h2AA,  1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
            '{10'h155,  1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
            '{10'd512,  1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
            '{10'd256,  1'b0, 1'b0, 1'b1, 1'b0, NO_RES},
            '{10'd0,    1'b0, 1'b1, 1'b0, 1'b1, TOGGLE_OK_NEW}
        };

        // hl, jt, off limit, on limit, windows, request odds, quiet, draw, hold, arm
        plan = '{
            '{10'd500,  10'd200,  8'd20,  8'd2,   12,  40, 1'b0, 1'b0, 1'b0, 1'b0},
            '{10'd0,    10'd0,    8'd0,   8'd0,   10,  25, 1'b0, 1'b0, 1'b0, 1'b0},
            '{10'd1023, 10'd1023, 8'd255, 8'd255, 8,   25, 1'b0, 1'b0, 1'b0, 1'b0},
            '{10'd300,  10'd50,   8'd3,   8'd1,   10, 150, 1'b1, 1'b0, 1'b0, 1'b0},
            '{10'd0,    10'd0,    8'd0,   8'd0,   10,  60, 1'b0, 1'b1, 1'b0, 1'b0},
            '{10'd700,  10'd400,  8'd20,  8'd5,   10, 400, 1'b0, 1'b0, 1'b0, 1'b0},
            '{10'd0,    10'd1023, 8'd255, 8'd0,   6,   30, 1'b0, 1'b0, 1'b0, 1'b0},
            '{10'd1023, 10'd0,    8'd0,   8'd255, 6,   30, 1'b1, 1'b0, 1'b0, 1'b0},
            '{10'd0,    10'd0,    8'd0,   8'd0,   10,  50, 1'b0, 1'b1, 1'b0, 1'b0},
            // off pending against a steady on line: timeout climbs window by window
            '{10'd100,  10'd1023, 8'd255, 8'd2,   16,   0, 1'b0, 1'b0, 1'b1, 1'b1},
            // a limit below the count reached makes the off request fail
            '{10'd100,  10'd1023, 8'd10,  8'd2,   3,    0, 1'b0, 1'b0, 1'b1, 1'b0}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[k]) begin
            it.level     = dir_tab[k].lvl;
            it.req_force = dir_tab[k].frc;
            it.req_off   = dir_tab[k].off;
            it.req_on    = dir_tab[k].on;
            send_sample(it, ended, res);
            if (ended)
                results_due.push_back(dir_tab[k].typed ? dir_tab[k].want : res);
        end

        foreach (plan[p]) begin
            drain();
            if (plan[p].draw)
                load_regs(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            else
                load_regs(plan[p].hl, plan[p].jt, plan[p].offl, plan[p].onl);
            quiet   = plan[p].quiet;
            n_items = plan[p].wins * WINDOW + (plan[p].hold ? 0 : $urandom_range(0, 7));
            for (int n = 0; n < n_items; n++) begin
                // one mid-phase pause with the sender held until all results are in
                if (p == 0 && n == n_items / 2)
                    drain();
                if (win_pos == 0) begin
                    shape   = plan[p].hold ? SHAPE_HIGH : t_shape'($urandom_range(0, 5));
                    step_at = $urandom_range(1, WINDOW - 1);
                    rising  = $urandom_range(0, 1);
                end
                it.level     = pick_level(win_pos);
                it.req_force = plan[p].div != 0 && $urandom_range(1, plan[p].div) == 1;
                it.req_off   = (plan[p].div != 0 && $urandom_range(1, plan[p].div) == 1)
                               || (plan[p].arm && win_pos == 0 && n < WINDOW);
                it.req_on    = plan[p].div != 0 && $urandom_range(1, plan[p].div) == 1;
                send_sample(it, ended, res);
                if (ended)
                    results_due.push_back(res);
            end
        end

        drain();
        repeat (SETTLE) @(posedge i_clk);

        $display("Covered %0d samples, %0d window results, %0d register settings.",
                 n_samples, n_results, n_cfg);
        $display("Status off/on/toggling %0d/%0d/%0d; action none/ok/failed %0d/%0d/%0d.",
                 st_seen[ST_OFF], st_seen[ST_ON], st_seen[ST_TOGGLE],
                 act_seen[ACT_NONE], act_seen[ACT_OK], act_seen[ACT_FAIL]);
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/lswc_pkg.sv
rtl/core/lswc_step.sv
rtl/core/load_state_window_classifier.sv
dv/load_state_window_classifier_tb.sv
